// File: design/pad_pkg.sv
// ----------------------------------------------------------------------------
// pad_pkg: shared constants for the polyphase audio downsampler
// Field codes, register indexes and fixed-point limits used across the design.
// ----------------------------------------------------------------------------
package pad_pkg;

   // Transaction kinds on the request channel.
   localparam logic FUNC_SAMPLE = 1'b0;
   localparam logic FUNC_COEF   = 1'b1;

   // Control register indexes.
   localparam logic [2:0] CSR_STEP_RATIO    = 3'd0;
   localparam logic [2:0] CSR_TAP_COUNT     = 3'd1;
   localparam logic [2:0] CSR_FILTERED_MODE = 3'd2;
   localparam logic [2:0] CSR_WIDE_SAMPLES  = 3'd3;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 24;
   localparam int SAMPLE_W    = 16;
   localparam int COEF_W      = 16;
   localparam int COEF_IDX_W  = 13;
   localparam int POS_W       = 32;
   localparam int FRAC_W      = 19;
   localparam int PHASE_LSB   = 11;
   localparam int PHASE_W     = 8;
   localparam int ACC_W       = 40;

   localparam logic [23:0] STEP_RESET = 24'd524288;
   localparam logic [23:0] MIN_STEP   = 24'h002000;
   localparam logic [31:0] ONE_SAMPLE = 32'h0008_0000;

   localparam logic signed [ACC_W-1:0] ROUND_HALF     = 40'sh00_0000_2000;
   localparam logic signed [ACC_W-1:0] WIDE_SUM_MIN   = -40'sh00_2000_0000;
   localparam logic signed [ACC_W-1:0] WIDE_SUM_MAX   = 40'sh00_1fff_dfff;
   localparam logic signed [ACC_W-1:0] NARROW_SUM_MAX = 40'sh00_003f_dfff;

   localparam logic [15:0] WIDE_POS_LIMIT  = 16'h7fff;
   localparam logic [15:0] WIDE_NEG_LIMIT  = 16'h8000;
   localparam logic [15:0] NARROW_LIMIT    = 16'h00ff;
   localparam logic [15:0] NARROW_SILENCE  = 16'h0080;

endpackage

// File: design/pad_ram.sv
// ----------------------------------------------------------------------------
// pad_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module pad_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: design/polyphase_audio_downsampler.sv
// ----------------------------------------------------------------------------
// polyphase_audio_downsampler: polyphase FIR / point sample-rate converter
// A sample transaction may yield a run of results. Throughput is one
// transaction at a time, set by the single multiply-accumulate over the
// window and table. Reset is synchronous; it restores the configuration
// and control registers and restarts the stream; the payload registers
// are not reset.
// ----------------------------------------------------------------------------
//
// The sample window lives in a small circular RAM addressed from a head
// pointer, so dropping samples off its front is only a pointer move. Slots
// not written since the last restart read as silence through one valid bit
// per slot. The coefficient table is a second RAM, written by coefficient
// transactions. A sequencer walks the taps one per cycle: the two RAMs are
// read together, the product is registered, then accumulated. MAX_TAPS is
// expected to be a power of two so that window addresses wrap naturally.
module polyphase_audio_downsampler #(
   parameter int MAX_TAPS = 32,
   parameter int PHASES   = 256,
   parameter int MAX_RUN  = 64
) (
   input  logic                           clock,
   input  logic                           reset,
   // request channel
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic                           req_func,
   input  logic [pad_pkg::SAMPLE_W-1:0]   req_sample_in,
   input  logic [pad_pkg::COEF_IDX_W-1:0] req_coef_index,
   input  logic signed [pad_pkg::COEF_W-1:0] req_coef_value,
   // result channel
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [pad_pkg::SAMPLE_W-1:0]   rsp_sample_out,
   output logic                           rsp_last_of_run,
   // control registers
   input  logic                           csr_write_en,
   input  logic [pad_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [pad_pkg::CSR_DATA_W-1:0] csr_wdata
);

   localparam int AW      = $clog2(MAX_TAPS);
   localparam int CW      = $clog2(MAX_TAPS + 1);
   localparam int TW      = $clog2(PHASES * MAX_TAPS);
   localparam int NW      = $clog2(MAX_RUN + 1);
   localparam int BASE_W  = pad_pkg::POS_W - pad_pkg::FRAC_W;

   localparam logic [3:0] ST_IDLE  = 4'd0;
   localparam logic [3:0] ST_CHECK = 4'd1;
   localparam logic [3:0] ST_POINT = 4'd2;
   localparam logic [3:0] ST_MAC   = 4'd3;
   localparam logic [3:0] ST_DRAIN = 4'd4;
   localparam logic [3:0] ST_RES   = 4'd5;
   localparam logic [3:0] ST_LAST  = 4'd6;
   localparam logic [3:0] ST_OUT   = 4'd7;
   localparam logic [3:0] ST_FIN   = 4'd8;

   // Configuration registers.
   logic [23:0] step_ratio_ff;
   logic [5:0]  tap_count_ff;
   logic        filtered_ff;
   logic        wide_ff;
   logic        restart_ff;

   // Stream state.
   logic [3:0]                 state_ff, state_in;
   logic [pad_pkg::POS_W-1:0]  pos_ff, pos_in;
   logic [AW-1:0]              head_ff, head_in;
   logic [CW-1:0]              count_ff, count_in;
   logic [MAX_TAPS-1:0]        slot_valid_ff, slot_valid_in;
   logic [NW-1:0]              run_ff, run_in;
   logic [CW-1:0]              tap_ff, tap_in;
   logic [TW-1:0]              coef_base_ff, coef_base_in;

   // Datapath registers.
   logic                       rd_vld_ff, rd_vld_in;
   logic                       rd_slot_ff;
   logic                       prod_vld_ff;
   logic signed [32:0]         prod_ff;
   logic signed [pad_pkg::ACC_W-1:0] acc_ff, acc_in;
   logic [pad_pkg::SAMPLE_W-1:0] res_ff, res_in;
   logic                       last_ff, last_in;

   // Derived configuration.
   logic [CW-1:0]              taps;
   logic [23:0]                step_eff;
   logic [pad_pkg::SAMPLE_W-1:0] silence;

   always_comb begin
      if (!filtered_ff || tap_count_ff == 6'd0) begin
         taps = CW'(1);
      end else if (32'(tap_count_ff) > MAX_TAPS) begin
         taps = CW'(MAX_TAPS);
      end else begin
         taps = CW'(tap_count_ff);
      end
      step_eff = (step_ratio_ff < pad_pkg::MIN_STEP) ? pad_pkg::MIN_STEP : step_ratio_ff;
      silence  = wide_ff ? '0 : pad_pkg::NARROW_SILENCE;
   end

   // Handshakes.
   logic req_fire, rsp_fire;
   assign req_ready = (state_ff == ST_IDLE) && !restart_ff;
   assign req_fire  = req_valid && req_ready;
   assign rsp_valid = (state_ff == ST_OUT);
   assign rsp_fire  = rsp_valid && rsp_ready;
   assign rsp_sample_out  = res_ff;
   assign rsp_last_of_run = last_ff;

   // Position split: integer sample offset and polyphase index.
   logic [BASE_W-1:0]          base;
   logic [pad_pkg::PHASE_W-1:0] phase;
   logic                       more;
   assign base  = pos_ff[pad_pkg::POS_W-1:pad_pkg::FRAC_W];
   assign phase = pos_ff[pad_pkg::PHASE_LSB +: pad_pkg::PHASE_W];
   // Another output is due when the run has not reached MAX_RUN and the window covers every tap it needs.
   assign more  = (32'(run_ff) < MAX_RUN) &&
                  ((BASE_W + 1)'(base) + (BASE_W + 1)'(taps) <= (BASE_W + 1)'(count_ff));

   // Accepting a sample: drop the oldest one first if the window is full.
   logic              win_full;
   logic [AW-1:0]     acc_head;
   logic [CW-1:0]     acc_count;
   logic [pad_pkg::POS_W-1:0] acc_pos;
   logic [pad_pkg::SAMPLE_W-1:0] sample_masked;
   always_comb begin
      win_full      = (32'(count_ff) >= MAX_TAPS);
      acc_head      = win_full ? head_ff + AW'(1) : head_ff;
      acc_count     = win_full ? CW'(MAX_TAPS - 1) : count_ff;
      if (!win_full) begin
         acc_pos = pos_ff;
      end else if (pos_ff >= pad_pkg::ONE_SAMPLE) begin
         acc_pos = pos_ff - pad_pkg::ONE_SAMPLE;
      end else begin
         acc_pos = '0;
      end
      sample_masked = wide_ff ? req_sample_in : {8'h00, req_sample_in[7:0]};
   end

   // Window RAM ports.
   logic          win_we;
   logic [AW-1:0] win_wr_addr;
   logic [AW-1:0] win_rd_addr;
   logic [pad_pkg::SAMPLE_W-1:0] win_rd_data;
   assign win_we      = req_fire && (req_func == pad_pkg::FUNC_SAMPLE);
   assign win_wr_addr = acc_head + acc_count[AW-1:0];
   assign win_rd_addr = head_ff + base[AW-1:0] + tap_ff[AW-1:0];

   pad_ram #(
      .WIDTH (pad_pkg::SAMPLE_W),
      .DEPTH (MAX_TAPS)
   ) u_window_ram (
      .clock   (clock),
      .wr_en   (win_we),
      .wr_addr (win_wr_addr),
      .wr_data (sample_masked),
      .rd_addr (win_rd_addr),
      .rd_data (win_rd_data)
   );

   // Coefficient RAM ports.
   logic          coef_we;
   logic [TW-1:0] coef_wr_addr;
   logic [TW-1:0] coef_rd_addr;
   logic [pad_pkg::COEF_W-1:0] coef_rd_data;
   assign coef_we      = req_fire && (req_func == pad_pkg::FUNC_COEF);
   assign coef_wr_addr = TW'(req_coef_index);
   assign coef_rd_addr = coef_base_ff + TW'(tap_ff);

   pad_ram #(
      .WIDTH (pad_pkg::COEF_W),
      .DEPTH (PHASES * MAX_TAPS)
   ) u_coef_ram (
      .clock   (clock),
      .wr_en   (coef_we),
      .wr_addr (coef_wr_addr),
      .wr_data (req_coef_value),
      .rd_addr (coef_rd_addr),
      .rd_data (coef_rd_data)
   );

   // Window sample as it enters the multiplier; unwritten slots are silence.
   logic [pad_pkg::SAMPLE_W-1:0] win_sample;
   logic signed [16:0]           mac_sample;
   assign win_sample = rd_slot_ff ? win_rd_data : silence;
   assign mac_sample = wide_ff ? {win_sample[15], win_sample}
                               : {9'd0, win_sample[7:0]};

   // Rounding and saturation of the accumulated sum.
   logic signed [pad_pkg::ACC_W-1:0] rounded;
   logic [pad_pkg::SAMPLE_W-1:0]     fir_result;
   always_comb begin
      rounded = (acc_ff + pad_pkg::ROUND_HALF) >>> 14;
      if (wide_ff) begin
         if (acc_ff < pad_pkg::WIDE_SUM_MIN) begin
            fir_result = pad_pkg::WIDE_NEG_LIMIT;
         end else if (acc_ff > pad_pkg::WIDE_SUM_MAX) begin
            fir_result = pad_pkg::WIDE_POS_LIMIT;
         end else begin
            fir_result = rounded[15:0];
         end
      end else begin
         if (acc_ff < 0) begin
            fir_result = '0;
         end else if (acc_ff > pad_pkg::NARROW_SUM_MAX) begin
            fir_result = pad_pkg::NARROW_LIMIT;
         end else begin
            fir_result = {8'h00, rounded[7:0]};
         end
      end
   end

   // Samples the position has passed are discarded at the end of a run.
   logic [CW-1:0] drop;
   assign drop = ((BASE_W + 1)'(base) > (BASE_W + 1)'(count_ff)) ? count_ff : CW'(base);

   // Sequencer.
   always_comb begin
      state_in      = state_ff;
      pos_in        = pos_ff;
      head_in       = head_ff;
      count_in      = count_ff;
      slot_valid_in = slot_valid_ff;
      run_in        = run_ff;
      tap_in        = tap_ff;
      coef_base_in  = coef_base_ff;
      rd_vld_in     = 1'b0;
      acc_in        = acc_ff;
      res_in        = res_ff;
      last_in       = last_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire && req_func == pad_pkg::FUNC_SAMPLE) begin
               head_in  = acc_head;
               count_in = acc_count + CW'(1);
               pos_in   = acc_pos;
               slot_valid_in[win_wr_addr] = 1'b1;
               run_in   = '0;
               tap_in   = '0;
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (!more) begin
               state_in = ST_FIN;
            end else if (filtered_ff) begin
               coef_base_in = TW'(phase * taps);
               acc_in       = '0;
               state_in     = ST_MAC;
            end else begin
               // Window read at the integer position is issued this cycle.
               state_in = ST_POINT;
            end
         end
         ST_POINT: begin
            res_in   = wide_ff ? win_sample : {8'h00, win_sample[7:0]};
            pos_in   = pos_ff + pad_pkg::POS_W'(step_eff);
            run_in   = run_ff + NW'(1);
            state_in = ST_LAST;
         end
         ST_MAC: begin
            rd_vld_in = 1'b1;
            tap_in    = tap_ff + CW'(1);
            if (tap_ff == taps - CW'(1)) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (!rd_vld_ff && !prod_vld_ff) begin
               state_in = ST_RES;
            end
         end
         ST_RES: begin
            res_in   = fir_result;
            pos_in   = pos_ff + pad_pkg::POS_W'(step_eff);
            run_in   = run_ff + NW'(1);
            state_in = ST_LAST;
         end
         ST_LAST: begin
            last_in  = !more;
            tap_in   = '0;
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (rsp_fire) begin
               state_in = ST_CHECK;
            end
         end
         ST_FIN: begin
            head_in  = head_ff + drop[AW-1:0];
            count_in = count_ff - drop;
            pos_in   = pos_ff - (pad_pkg::POS_W'(drop) << pad_pkg::FRAC_W);
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (prod_vld_ff) begin
         acc_in = acc_ff + {{(pad_pkg::ACC_W - 33){prod_ff[32]}}, prod_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ratio_ff <= pad_pkg::STEP_RESET;
         tap_count_ff  <= 6'd1;
         filtered_ff   <= 1'b0;
         wide_ff       <= 1'b1;
         restart_ff    <= 1'b1;
         state_ff      <= ST_IDLE;
         rd_vld_ff     <= 1'b0;
         prod_vld_ff   <= 1'b0;
      end else begin
         restart_ff <= csr_write_en &&
                       (csr_index == pad_pkg::CSR_STEP_RATIO ||
                        csr_index == pad_pkg::CSR_TAP_COUNT ||
                        csr_index == pad_pkg::CSR_FILTERED_MODE ||
                        csr_index == pad_pkg::CSR_WIDE_SAMPLES);
         if (csr_write_en) begin
            unique case (csr_index)
               pad_pkg::CSR_STEP_RATIO: begin
                  step_ratio_ff <= csr_wdata;
               end
               pad_pkg::CSR_TAP_COUNT: begin
                  tap_count_ff <= csr_wdata[5:0];
               end
               pad_pkg::CSR_FILTERED_MODE: begin
                  filtered_ff <= csr_wdata[0];
               end
               pad_pkg::CSR_WIDE_SAMPLES: begin
                  wide_ff <= csr_wdata[0];
               end
               default: begin
               end
            endcase
         end
         state_ff    <= state_in;
         rd_vld_ff   <= rd_vld_in;
         prod_vld_ff <= rd_vld_ff;
      end
   end

   // Stream state; a restart uses the register values written just before.
   always_ff @(posedge clock) begin
      if (reset || restart_ff) begin
         pos_ff        <= '0;
         head_ff       <= '0;
         count_ff      <= reset ? '0 : (taps >> 1);
         slot_valid_ff <= '0;
      end else begin
         pos_ff        <= pos_in;
         head_ff       <= head_in;
         count_ff      <= count_in;
         slot_valid_ff <= slot_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      run_ff       <= run_in;
      tap_ff       <= tap_in;
      coef_base_ff <= coef_base_in;
      rd_slot_ff   <= slot_valid_ff[win_rd_addr];
      prod_ff      <= $signed(coef_rd_data) * mac_sample;
      acc_ff       <= acc_in;
      res_ff       <= res_in;
      last_ff      <= last_in;
   end

   // Checks on the sequencer.
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid))
      else $error("request taken while a result is pending");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      32'(count_ff) <= MAX_TAPS)
      else $error("window count beyond its depth");

   a_coef_no_result: assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_func == pad_pkg::FUNC_COEF) |=> (state_ff == ST_IDLE))
      else $error("coefficient transaction started a run");

   a_mac_drained: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RES) |-> (!rd_vld_ff && !prod_vld_ff))
      else $error("result taken before the accumulation finished");

endmodule
